[design/fpr_pkg.sv]
// Shared types and constants for the flight phase recorder.
`timescale 1ns / 1ps

package fpr_pkg;

   localparam int SLOTS_PER_PAGE = 4;

   localparam int ALT_W      = 24;
   localparam int LAUNCH_W   = 21;
   localparam int MARGIN_W   = 17;
   localparam int LAND_W     = 22;
   localparam int HOLD_W     = 16;
   localparam int PAGE_W     = 24;
   localparam int SLOT_W     = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USED_W = 62;

   localparam logic [CSR_IDX_W-1:0] REG_LAUNCH_ALT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_APOGEE_MARG = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAND_ALT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAND_HOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_CAP    = 3'd4;

   localparam logic [LAUNCH_W-1:0] LAUNCH_ALT_RESET  = 21'd3000;
   localparam logic [MARGIN_W-1:0] APOGEE_MARG_RESET = 17'd500;
   localparam logic [LAND_W-1:0]   LAND_ALT_RESET    = 22'd1000;
   localparam logic [HOLD_W-1:0]   LAND_HOLD_RESET   = 16'd100;
   localparam logic [PAGE_W-1:0]   PAGE_CAP_RESET    = 24'd65536;

   typedef enum logic [1:0] {
      PH_PRELAUNCH = 2'd0,
      PH_ASCEND    = 2'd1,
      PH_DESCEND   = 2'd2,
      PH_DONE      = 2'd3
   } phase_type;

   typedef struct packed {
      logic [LAUNCH_W-1:0]      launch_alt;
      logic [MARGIN_W-1:0]      apogee_margin;
      logic signed [LAND_W-1:0] land_alt;
      logic [HOLD_W-1:0]        land_hold;
      logic [PAGE_W-1:0]        page_capacity;
   } config_type;

   typedef struct packed {
      phase_type               phase;
      logic signed [ALT_W-1:0] peak_alt;
      logic [HOLD_W-1:0]       low_hold;
      logic [SLOT_W-1:0]       slot;
      logic [PAGE_W-1:0]       page;
   } state_type;

   typedef struct packed {
      logic              full_stop;
      logic              landed_event;
      logic              apogee_event;
      logic              launch_event;
      logic [PAGE_W-1:0] flush_page;
      logic              flush;
      logic [PAGE_W-1:0] page_index;
      logic [SLOT_W-1:0] slot_index;
      logic              recorded;
      phase_type         phase;
   } result_type;

endpackage

[design/fpr_step.sv]
// Next-state and result logic for one altitude sample.
`timescale 1ns / 1ps

module fpr_step (
   input  fpr_pkg::config_type              cfg,
   input  fpr_pkg::state_type               state,
   input  logic signed [fpr_pkg::ALT_W-1:0] altitude,
   output fpr_pkg::state_type               state_next,
   output fpr_pkg::result_type              result
);

   localparam logic [fpr_pkg::SLOT_W:0] SLOTS =
      (fpr_pkg::SLOT_W + 1)'(fpr_pkg::SLOTS_PER_PAGE);

   logic signed [fpr_pkg::ALT_W:0]   alt_ext;
   logic signed [fpr_pkg::ALT_W:0]   peak_ext;
   logic signed [fpr_pkg::ALT_W:0]   launch_ext;
   logic signed [fpr_pkg::ALT_W+1:0] peak_floor;
   logic signed [fpr_pkg::ALT_W:0]   land_ext;
   logic [fpr_pkg::SLOT_W:0]         slot_inc;
   logic [fpr_pkg::HOLD_W-1:0]       hold_new;
   logic                             page_full;

   always_comb begin
      alt_ext    = {altitude[fpr_pkg::ALT_W-1], altitude};
      peak_ext   = {state.peak_alt[fpr_pkg::ALT_W-1], state.peak_alt};
      launch_ext = $signed({4'b0000, cfg.launch_alt});
      peak_floor = $signed({{2{state.peak_alt[fpr_pkg::ALT_W-1]}}, state.peak_alt})
                 - $signed({9'd0, cfg.apogee_margin});
      land_ext   = $signed({{3{cfg.land_alt[fpr_pkg::LAND_W-1]}}, cfg.land_alt});
      slot_inc   = {1'b0, state.slot} + (fpr_pkg::SLOT_W + 1)'(1);
      page_full  = slot_inc >= SLOTS;
      if (alt_ext > land_ext) begin
         hold_new = '0;
      end else if (state.low_hold != '1) begin
         hold_new = state.low_hold + fpr_pkg::HOLD_W'(1);
      end else begin
         hold_new = state.low_hold;
      end

      state_next = state;
      result     = '0;

      case (state.phase)
         fpr_pkg::PH_PRELAUNCH: begin
            if (alt_ext >= launch_ext) begin
               result.launch_event = 1'b1;
               state_next.slot     = '0;
               state_next.page     = '0;
               state_next.phase    = fpr_pkg::PH_ASCEND;
            end
         end
         fpr_pkg::PH_ASCEND, fpr_pkg::PH_DESCEND: begin
            if (state.page >= cfg.page_capacity) begin
               result.full_stop = 1'b1;
               state_next.phase = fpr_pkg::PH_DONE;
            end else begin
               result.recorded   = 1'b1;
               result.slot_index = state.slot;
               result.page_index = state.page;
               if (page_full) begin
                  result.flush      = 1'b1;
                  result.flush_page = state.page;
                  state_next.page   = state.page + fpr_pkg::PAGE_W'(1);
                  state_next.slot   = '0;
               end else begin
                  state_next.slot = slot_inc[fpr_pkg::SLOT_W-1:0];
               end
               if (state.phase == fpr_pkg::PH_ASCEND) begin
                  if (alt_ext > peak_ext) begin
                     state_next.peak_alt = altitude;
                  end else if ($signed({alt_ext[fpr_pkg::ALT_W], alt_ext}) < peak_floor) begin
                     result.apogee_event = 1'b1;
                     state_next.phase    = fpr_pkg::PH_DESCEND;
                  end
               end else begin
                  state_next.low_hold = hold_new;
                  if (hold_new >= cfg.land_hold) begin
                     result.landed_event = 1'b1;
                     state_next.phase    = fpr_pkg::PH_DONE;
                     if (!page_full) begin
                        result.flush      = 1'b1;
                        result.flush_page = state.page;
                        state_next.page   = state.page + fpr_pkg::PAGE_W'(1);
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      result.phase = state_next.phase;
   end

endmodule

[design/flight_phase_recorder_unit.sv]
// Top level of the flight phase recorder with its register file and output register.
// Output: a registered result appears in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless the receiver stalls; the phase, peak,
// hold and page registers update in the same cycle that accepts the sample.
// Reset: synchronous and active high; the phase returns to prelaunch, all
// counters clear and the configuration registers take their default values.
`timescale 1ns / 1ps

module flight_phase_recorder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [fpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: altitude_cm.
   input  logic [fpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: phase, recorded, slot_index, page_index, flush,
   // flush_page, launch_event, apogee_event, landed_event, full_stop, zero fill.
   output logic [fpr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   fpr_pkg::config_type cfg_ff;
   fpr_pkg::state_type  state_ff;
   fpr_pkg::state_type  state_in;
   fpr_pkg::result_type result_in;
   fpr_pkg::result_type result_ff;
   logic                rsp_valid_ff;
   logic                take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(fpr_pkg::RSP_DATA_W - fpr_pkg::RSP_USED_W){1'b0}}, result_ff};

   fpr_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .altitude   ($signed(req_tdata[fpr_pkg::ALT_W-1:0])),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.launch_alt    <= fpr_pkg::LAUNCH_ALT_RESET;
         cfg_ff.apogee_margin <= fpr_pkg::APOGEE_MARG_RESET;
         cfg_ff.land_alt      <= fpr_pkg::LAND_ALT_RESET;
         cfg_ff.land_hold     <= fpr_pkg::LAND_HOLD_RESET;
         cfg_ff.page_capacity <= fpr_pkg::PAGE_CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fpr_pkg::REG_LAUNCH_ALT:
               cfg_ff.launch_alt <= csr_wdata[fpr_pkg::LAUNCH_W-1:0];
            fpr_pkg::REG_APOGEE_MARG:
               cfg_ff.apogee_margin <= csr_wdata[fpr_pkg::MARGIN_W-1:0];
            fpr_pkg::REG_LAND_ALT:
               cfg_ff.land_alt <= $signed(csr_wdata[fpr_pkg::LAND_W-1:0]);
            fpr_pkg::REG_LAND_HOLD:
               cfg_ff.land_hold <= csr_wdata[fpr_pkg::HOLD_W-1:0];
            fpr_pkg::REG_PAGE_CAP:
               cfg_ff.page_capacity <= csr_wdata[fpr_pkg::PAGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

[verif/tb_flight_phase_recorder_unit.sv]
// Self-checking testbench for the flight phase recorder: one full flight with randomized idling.
`timescale 1ns / 1ps

module tb_flight_phase_recorder_unit;
   import fpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ALT_MIN        = -2000000;
   localparam int ALT_MAX        = 5000000;
   localparam int LAND_ALT_MIN   = -100000;
   localparam int LAND_ALT_MAX   = 2000000;
   localparam int LAUNCH_MAX     = 2000000;
   localparam int MARGIN_MAX     = 100000;
   localparam int HOLD_MAX       = 65535;
   localparam int CAPACITY_MAX   = 16777215;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [ALT_W-1:0] pending_altitudes[$];
   result_type       predicted_results[$];
   idle_mode_type    idle_mode = IDLE_NONE;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               samples_queued = 0;

   config_type              flight_cfg;
   phase_type               flight_phase;
   logic signed [ALT_W-1:0] peak_alt;
   logic [HOLD_W-1:0]       low_run;
   logic [SLOT_W-1:0]       slot_count;
   logic [PAGE_W-1:0]       page_count;

   flight_phase_recorder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic result_type advance_flight(input logic signed [ALT_W-1:0] alt);
      result_type r;
      longint     a;
      r = '0;
      a = alt;
      case (flight_phase)
         PH_PRELAUNCH: begin
            if (a >= longint'(flight_cfg.launch_alt)) begin
               r.launch_event = 1'b1;
               slot_count     = '0;
               page_count     = '0;
               flight_phase   = PH_ASCEND;
            end
         end
         PH_ASCEND, PH_DESCEND: begin
            if (page_count >= flight_cfg.page_capacity) begin
               r.full_stop  = 1'b1;
               flight_phase = PH_DONE;
            end else begin
               r.recorded   = 1'b1;
               r.slot_index = slot_count;
               r.page_index = page_count;
               if (int'(slot_count) + 1 >= SLOTS_PER_PAGE) begin
                  r.flush      = 1'b1;
                  r.flush_page = page_count;
                  page_count   = page_count + 1'b1;
                  slot_count   = '0;
               end else begin
                  slot_count = slot_count + 1'b1;
               end
               if (flight_phase == PH_ASCEND) begin
                  if (a > longint'(peak_alt)) begin
                     peak_alt = alt;
                  end else if (a < longint'(peak_alt) - longint'(flight_cfg.apogee_margin)) begin
                     r.apogee_event = 1'b1;
                     flight_phase   = PH_DESCEND;
                  end
               end else begin
                  if (a <= longint'($signed(flight_cfg.land_alt))) begin
                     if (low_run != '1) low_run = low_run + 1'b1;
                  end else begin
                     low_run = '0;
                  end
                  if (low_run >= flight_cfg.land_hold) begin
                     r.landed_event = 1'b1;
                     if (slot_count != '0) begin
                        r.flush      = 1'b1;
                        r.flush_page = page_count;
                        page_count   = page_count + 1'b1;
                     end
                     flight_phase = PH_DONE;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.phase = flight_phase;
      return r;
   endfunction

   function automatic int rand_alt(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic bit sender_pauses();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 76;
         IDLE_BOTH:   return $urandom_range(0, 99) < 13;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 76;
         IDLE_BOTH:     return $urandom_range(0, 99) < 13;
         default:       return 1'b0;
      endcase
   endfunction

   task automatic queue_sample(input int alt);
      while (pending_altitudes.size() >= 8) @(posedge clock);
      predicted_results.push_back(advance_flight(alt[ALT_W-1:0]));
      pending_altitudes.push_back(alt[ALT_W-1:0]);
      samples_queued++;
      if (samples_queued % 60 == 0) idle_mode = idle_mode_type'((int'(idle_mode) + 1) % 4);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      while (pending_altitudes.size() != 0 || predicted_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_LAUNCH_ALT:  flight_cfg.launch_alt    = value[LAUNCH_W-1:0];
         REG_APOGEE_MARG: flight_cfg.apogee_margin = value[MARGIN_W-1:0];
         REG_LAND_ALT:    flight_cfg.land_alt      = value[LAND_W-1:0];
         REG_LAND_HOLD:   flight_cfg.land_hold     = value[HOLD_W-1:0];
         REG_PAGE_CAP:    flight_cfg.page_capacity = value[PAGE_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_altitudes.size() != 0 && !sender_pauses()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_altitudes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_USED_W-1:0]);
            if (predicted_results.size() == 0) begin
               $error("result transfer with no prediction waiting: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("phase", want.phase, got.phase);
               check_field("recorded", want.recorded, got.recorded);
               check_field("slot_index", want.slot_index, got.slot_index);
               check_field("page_index", want.page_index, got.page_index);
               check_field("flush", want.flush, got.flush);
               check_field("flush_page", want.flush_page, got.flush_page);
               check_field("launch_event", want.launch_event, got.launch_event);
               check_field("apogee_event", want.apogee_event, got.apogee_event);
               check_field("landed_event", want.landed_event, got.landed_event);
               check_field("full_stop", want.full_stop, got.full_stop);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int ending;
      int margin;
      int launch_at;
      int land_now;
      int alt;
      int seg;
      int n_ascend;

      flight_cfg.launch_alt    = LAUNCH_ALT_RESET;
      flight_cfg.apogee_margin = APOGEE_MARG_RESET;
      flight_cfg.land_alt      = LAND_ALT_RESET;
      flight_cfg.land_hold     = LAND_HOLD_RESET;
      flight_cfg.page_capacity = PAGE_CAP_RESET;
      flight_phase = PH_PRELAUNCH;
      peak_alt     = '0;
      low_run      = '0;
      slot_count   = '0;
      page_count   = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      queue_sample(ALT_MIN);
      queue_sample(-1);
      queue_sample(0);
      queue_sample(int'(LAUNCH_ALT_RESET) - 1);

      write_csr(REG_LAUNCH_ALT, LAUNCH_MAX);
      write_csr(REG_LAND_ALT, LAND_ALT_MIN);
      write_csr(REG_LAND_HOLD, HOLD_MAX);
      write_csr(REG_PAGE_CAP, CAPACITY_MAX);
      queue_sample(LAUNCH_MAX - 1);
      repeat (200) queue_sample(rand_alt(ALT_MIN, LAUNCH_MAX - 1));

      ending = $urandom_range(0, 3);
      case ($urandom_range(0, 2))
         0:       margin = 0;
         1:       margin = MARGIN_MAX;
         default: margin = rand_alt(1, MARGIN_MAX);
      endcase
      write_csr(REG_APOGEE_MARG, margin);
      launch_at = ($urandom_range(0, 1) == 0) ? 0 : rand_alt(1, 20000);
      write_csr(REG_LAUNCH_ALT, launch_at);
      repeat (3) queue_sample(rand_alt(ALT_MIN, launch_at - 1));
      queue_sample(launch_at);

      // Right at peak minus margin is still no apogee.
      queue_sample(int'(peak_alt) - margin);
      n_ascend = (ending <= 1) ? 600 : 200;
      repeat (n_ascend) begin
         if ($urandom_range(0, 3) != 0) begin
            alt = int'(peak_alt) + rand_alt(1, 15000);
            if (alt > ALT_MAX) alt = ALT_MAX;
         end else begin
            alt = int'(peak_alt) - rand_alt(0, margin);
         end
         queue_sample(alt);
      end
      queue_sample(ALT_MAX);

      if (ending == 0) begin
         write_csr(REG_PAGE_CAP, 0);
         queue_sample(ALT_MAX);
      end else begin
         if (ending == 1) write_csr(REG_LAND_HOLD, 0);
         queue_sample(int'(peak_alt) - margin - 1 - rand_alt(0, 1000));
         if (ending == 1) begin
            queue_sample(rand_alt(ALT_MIN, ALT_MAX));
         end else begin
            for (seg = 0; seg < 3; seg++) begin
               case (seg)
                  0:       write_csr(REG_LAND_ALT, LAND_ALT_MAX);
                  1:       write_csr(REG_LAND_ALT, LAND_ALT_MIN);
                  default: write_csr(REG_LAND_ALT, rand_alt(LAND_ALT_MIN, LAND_ALT_MAX));
               endcase
               write_csr(REG_LAND_HOLD, (seg == 0) ? HOLD_MAX : rand_alt(2, 40));
               land_now = int'($signed(flight_cfg.land_alt));
               repeat (150) begin
                  alt = rand_alt(ALT_MIN, ALT_MAX);
                  // Keep low runs one short of the hold so the flight goes on.
                  if (alt <= land_now && int'(low_run) + 1 >= int'(flight_cfg.land_hold)) begin
                     alt = land_now + 1 + rand_alt(0, 1000);
                  end
                  queue_sample(alt);
               end
            end
            land_now = int'($signed(flight_cfg.land_alt));
            if (ending == 2) begin
               write_csr(REG_LAND_HOLD, rand_alt(1, 8));
               while (flight_phase != PH_DONE) queue_sample(rand_alt(ALT_MIN, land_now));
            end else begin
               write_csr(REG_PAGE_CAP, int'(page_count) + rand_alt(1, 3));
               while (flight_phase != PH_DONE) queue_sample(rand_alt(land_now + 1, ALT_MAX));
            end
         end
      end

      repeat (12) queue_sample(rand_alt(ALT_MIN, ALT_MAX));

      while (predicted_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
design/fpr_pkg.sv
design/fpr_step.sv
design/flight_phase_recorder_unit.sv
verif/tb_flight_phase_recorder_unit.sv
